// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants for the bitmap frame allocator
// Field widths, operation and status codes, and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

   // payload field widths
   localparam int OP_W     = 3;
   localparam int FRAME_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;
   // frame arithmetic width: holds first_frame + frame_count
   localparam int POS_W    = 12;

   // frames examined per search step
   localparam int LANE_BITS = 8;

   // block_count after reset
   localparam logic [COUNT_W-1:0] BC_RESET = 11'd1024;

   // operation codes
   localparam logic [OP_W-1:0] OP_INIT        = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC       = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE     = 3'd2;
   localparam logic [OP_W-1:0] OP_MARK_USED   = 3'd3;
   localparam logic [OP_W-1:0] OP_MARK_UNUSED = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

   // what a captured request needs from the map
   typedef enum logic [1:0] {
      PLAN_NONE,
      PLAN_FILL,
      PLAN_SEARCH,
      PLAN_RANGE
   } plan_type;

   // controller to datapath
   typedef struct packed {
      logic start;     // capture request, rewind to word 0
      logic fill;      // write all ones at current word, advance
      logic rd;        // issue map read at current word
      logic lane;      // search one lane of the read word
      logic adv;       // step search to next word
      logic to_write;  // rewind to word 0 for the write pass
      logic modify;    // write modified word, advance
      logic commit;    // update used count, load response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      plan_type plan;
      logic     word_last;
      logic     lane_hit;
      logic     lane_last;
      logic     search_done;
      logic     range_done;
   } stat_type;

endpackage

// ===== hw/rtl/bfa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfa_req_if: request channel
// Valid/ready channel carrying one allocator operation.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [FRAME_W-1:0] first_frame;
   logic [COUNT_W-1:0] frame_count;

   modport source (output valid, output op, output first_frame, output frame_count,
                   input ready);
   modport sink   (input valid, input op, input first_frame, input frame_count,
                   output ready);
endinterface

// ===== hw/rtl/bfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfa_rsp_if: response channel
// Valid/ready channel carrying the outcome of one operation.
// ----------------------------------------------------------------------------
interface bfa_rsp_if import bfa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRAME_W-1:0]  start_frame;
   logic [COUNT_W-1:0]  used_frames;
   logic [COUNT_W-1:0]  free_frames;

   modport source (output valid, output status, output start_frame, output used_frames,
                   output free_frames, input ready);
   modport sink   (input valid, input status, input start_frame, input used_frames,
                   input free_frames, output ready);
endinterface

// ===== hw/rtl/bfa_csr_if.sv =====
// ----------------------------------------------------------------------------
// bfa_csr_if: configuration write channel
// Valid/ready channel carrying a new block_count value.
// ----------------------------------------------------------------------------
interface bfa_csr_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

// ===== hw/rtl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that holds its
// data until the next read.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl: allocator sequencer
// Steps the datapath through the reset sweep, the init fill, the first-fit
// search, the read-modify-write pass and the response hand-off.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PLAN,
      S_FILL,
      S_SRD,
      S_SLANE,
      S_WRD,
      S_WMOD,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.fill = 1'b1;
            if (stat.word_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_PLAN;
            end
         end
         S_PLAN: begin
            unique case (stat.plan)
               PLAN_FILL:   state_in = S_FILL;
               PLAN_SEARCH: state_in = S_SRD;
               PLAN_RANGE:  state_in = S_WRD;
               default:     state_in = S_FIN;
            endcase
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (stat.word_last) state_in = S_FIN;
         end
         S_SRD: begin
            cmd.rd   = 1'b1;
            state_in = S_SLANE;
         end
         S_SLANE: begin
            cmd.lane = 1'b1;
            if (stat.lane_hit) begin
               cmd.to_write = 1'b1;
               state_in     = S_WRD;
            end else if (stat.lane_last) begin
               if (stat.search_done) begin
                  state_in = S_FIN;
               end else begin
                  cmd.adv  = 1'b1;
                  state_in = S_SRD;
               end
            end
         end
         S_WRD: begin
            cmd.rd   = 1'b1;
            state_in = S_WMOD;
         end
         S_WMOD: begin
            cmd.modify = 1'b1;
            state_in   = stat.range_done ? S_FIN : S_WRD;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/bfa_dpath.sv =====
// ----------------------------------------------------------------------------
// bfa_dpath: allocator datapath
// Frame map RAM, request and configuration registers, the lane-wise run
// search, the range mask writer and the used-frame counter.
// ----------------------------------------------------------------------------
module bfa_dpath import bfa_pkg::*; #(
   parameter int MAX_FRAMES    = 1024,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_op,
   input  logic [FRAME_W-1:0]  req_first,
   input  logic [COUNT_W-1:0]  req_count,
   input  logic                cfg_we,
   input  logic [COUNT_W-1:0]  cfg_data,
   input  cmd_type             cmd,
   output stat_type            stat,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FRAME_W-1:0]  rsp_start,
   output logic [COUNT_W-1:0]  rsp_used,
   output logic [COUNT_W-1:0]  rsp_free
);

   localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int LANES     = (MAP_WORD_BITS + LANE_BITS - 1) / LANE_BITS;
   localparam int LW        = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int EW        = LANES * LANE_BITS;
   localparam int OW        = $clog2(EW + 1);
   localparam int CNT_MAX   = (1 << COUNT_W) - 1;
   localparam int MAX_EFF   = (MAX_FRAMES > CNT_MAX) ? CNT_MAX : MAX_FRAMES;
   localparam int USED_RST  = (MAX_FRAMES < int'(BC_RESET)) ? MAX_FRAMES : int'(BC_RESET);

   localparam logic [AW-1:0]      LAST_ADDR = AW'(MAP_WORDS - 1);
   localparam logic [LW-1:0]      LAST_LANE = LW'(LANES - 1);
   localparam logic [POS_W-1:0]   WORD_STEP = POS_W'(MAP_WORD_BITS);
   localparam logic [COUNT_W-1:0] EFF_CAP   = COUNT_W'(MAX_EFF);
   localparam logic [OW-1:0]      WORD_LEN  = OW'(MAP_WORD_BITS);

   // control registers
   logic [COUNT_W-1:0] bc_cfg_ff;
   logic [COUNT_W-1:0] used_ff;
   logic [AW-1:0]      addr_ff;
   // request and scan registers
   logic [OP_W-1:0]    op_ff;
   logic [FRAME_W-1:0] first_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [COUNT_W-1:0] bc_ff;
   logic [POS_W-1:0]   base_ff;
   logic [LW-1:0]      lane_ff;
   logic [COUNT_W-1:0] run_ff;
   logic               hit_ff;
   logic [POS_W-1:0]   pos_ff;
   // response registers
   logic [STATUS_W-1:0] status_ff;
   logic [FRAME_W-1:0]  start_ff;
   logic [COUNT_W-1:0]  rused_ff;
   logic [COUNT_W-1:0]  rfree_ff;

   logic [MAP_WORD_BITS-1:0] ram_rdata, ram_wdata, mod_word, mask;
   logic                     ram_we;

   logic [COUNT_W-1:0]  bc_eff, freec, used_next, free_next, add_v, sub_v;
   logic [POS_W-1:0]    sum_v, lim_lo, lim_hi;
   logic                is_alloc, is_set, is_range_op, force0, range_bad;
   logic [STATUS_W-1:0] pre_status, status_next;
   plan_type            plan;
   logic                word_last;

   logic [EW-1:0]       lane_word;
   logic [OW-1:0]       lane_off;
   logic [COUNT_W-1:0]  run_v;
   logic                hit_v;
   logic [POS_W-1:0]    pos_v;

   // frame map
   bfa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (ram_wdata),
      .re    (cmd.rd),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign ram_we    = cmd.fill | cmd.modify;
   assign ram_wdata = cmd.fill ? '1 : mod_word;

   // limit block_count to the map size
   assign bc_eff = (bc_cfg_ff > EFF_CAP) ? EFF_CAP : bc_cfg_ff;

   // decode captured request
   always_comb begin
      is_alloc    = (op_ff == OP_ALLOC);
      is_set      = (op_ff == OP_ALLOC) || (op_ff == OP_MARK_USED);
      is_range_op = (op_ff == OP_RELEASE) || (op_ff == OP_MARK_USED) ||
                    (op_ff == OP_MARK_UNUSED);
      force0      = (op_ff == OP_MARK_UNUSED);
      freec       = (used_ff >= bc_ff) ? '0 : bc_ff - used_ff;
      range_bad   = (cnt_ff == '0) ||
                    ((POS_W'(first_ff) + POS_W'(cnt_ff)) > POS_W'(bc_ff));
      case (op_ff) inside
         OP_ALLOC: begin
            if ((cnt_ff == '0) || (cnt_ff > bc_ff)) pre_status = ST_BAD;
            else if (freec < cnt_ff)                pre_status = ST_NOSPACE;
            else                                    pre_status = ST_OK;
         end
         OP_RELEASE, OP_MARK_USED, OP_MARK_UNUSED: begin
            pre_status = range_bad ? ST_BAD : ST_OK;
         end
         default: pre_status = ST_OK;
      endcase
      if (op_ff == OP_INIT)                          plan = PLAN_FILL;
      else if (is_alloc && (pre_status == ST_OK))    plan = PLAN_SEARCH;
      else if (is_range_op && (pre_status == ST_OK)) plan = PLAN_RANGE;
      else                                           plan = PLAN_NONE;
      status_next = ((plan == PLAN_SEARCH) && !hit_ff) ? ST_NOSPACE : pre_status;
      lim_lo      = is_alloc ? pos_ff : POS_W'(first_ff);
      lim_hi      = lim_lo + POS_W'(cnt_ff);
   end

   // search one lane of the read word for a run of free frames
   always_comb begin
      logic [OW-1:0]    j;
      logic [POS_W-1:0] f;
      lane_off  = OW'(lane_ff) * OW'(LANE_BITS);
      lane_word = EW'(ram_rdata) >> lane_off;
      run_v     = run_ff;
      hit_v     = 1'b0;
      pos_v     = pos_ff;
      for (int k = 0; k < LANE_BITS; k++) begin
         j = lane_off + OW'(k);
         f = base_ff + POS_W'(lane_off) + POS_W'(k);
         if (!hit_v && (j < WORD_LEN) && (f < POS_W'(bc_ff))) begin
            if (lane_word[k]) begin
               run_v = '0;
            end else begin
               run_v = run_v + 1'b1;
               if (run_v == cnt_ff) begin
                  hit_v = 1'b1;
                  pos_v = f + 1'b1 - POS_W'(cnt_ff);
               end
            end
         end
      end
   end

   // build the written word: set or clear frames in range
   always_comb begin
      logic [POS_W-1:0] f;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         f       = base_ff + POS_W'(j);
         mask[j] = (f >= lim_lo) && (f < lim_hi);
      end
      mod_word = is_set ? (ram_rdata | mask) : (ram_rdata & ~mask);
      if (force0 && (base_ff == '0)) mod_word[0] = 1'b1;
   end

   // saturating used count
   always_comb begin
      sum_v = POS_W'(used_ff) + POS_W'(cnt_ff);
      add_v = (sum_v > POS_W'(bc_ff)) ? bc_ff : COUNT_W'(sum_v);
      sub_v = (cnt_ff > used_ff) ? '0 : used_ff - cnt_ff;
      case (plan)
         PLAN_FILL:   used_next = bc_ff;
         PLAN_SEARCH: used_next = hit_ff ? add_v : used_ff;
         PLAN_RANGE:  used_next = is_set ? add_v : sub_v;
         default:     used_next = used_ff;
      endcase
      free_next = (used_next >= bc_ff) ? '0 : bc_ff - used_next;
   end

   assign word_last = (addr_ff == LAST_ADDR);

   always_comb begin
      stat.plan        = plan;
      stat.word_last   = word_last;
      stat.lane_hit    = hit_v;
      stat.lane_last   = (lane_ff == LAST_LANE);
      stat.search_done = word_last || ((base_ff + WORD_STEP) >= POS_W'(bc_ff));
      stat.range_done  = word_last || ((base_ff + WORD_STEP) >= lim_hi);
   end

   // configuration, used count and word address
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_cfg_ff <= BC_RESET;
         used_ff   <= COUNT_W'(USED_RST);
         addr_ff   <= '0;
      end else begin
         if (cfg_we) bc_cfg_ff <= cfg_data;
         if (cmd.commit) used_ff <= used_next;
         if (cmd.start || cmd.to_write) begin
            addr_ff <= '0;
         end else if (cmd.fill || cmd.adv || cmd.modify) begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   // request capture, scan position and response payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_op;
         first_ff <= req_first;
         cnt_ff   <= req_count;
         bc_ff    <= bc_eff;
         run_ff   <= '0;
         hit_ff   <= 1'b0;
      end
      if (cmd.start || cmd.to_write) begin
         base_ff <= '0;
      end else if (cmd.adv || cmd.modify) begin
         base_ff <= base_ff + WORD_STEP;
      end
      if (cmd.start || cmd.adv) begin
         lane_ff <= '0;
      end else if (cmd.lane) begin
         lane_ff <= (lane_ff == LAST_LANE) ? '0 : lane_ff + 1'b1;
      end
      if (cmd.lane) begin
         run_ff <= run_v;
         hit_ff <= hit_v;
         pos_ff <= pos_v;
      end
      if (cmd.commit) begin
         status_ff <= status_next;
         start_ff  <= ((plan == PLAN_SEARCH) && hit_ff) ? FRAME_W'(pos_ff) : first_ff;
         rused_ff  <= used_next;
         rfree_ff  <= free_next;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_start  = start_ff;
   assign rsp_used   = rused_ff;
   assign rsp_free   = rfree_ff;

endmodule

// ===== hw/rtl/bitmap_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top: first-fit bitmap allocator of physical frames
// Keeps a used/free bit per frame in a word-wide RAM and a used-frame count;
// runs init, alloc, release, mark used and mark unused requests.
// ----------------------------------------------------------------------------
// One request is worked at a time; the response sits in an output register,
// so the next request is taken while it waits. Init sweeps the whole map,
// writing one map word per cycle. Release and the marks walk the map words
// from word 0 through the word holding the last frame of the range, each
// word one RAM read followed by one write. Alloc scans the map from frame
// 0, each word one read and then its lanes of eight frames (eight frames
// per cycle), up to the word where the run completes or block_count ends,
// then runs the same read-then-write pass; a refused or malformed request
// goes straight to its response. After reset the block sweeps every map
// word to ones before it takes its first request; configuration writes are
// accepted at any time.
module bitmap_frame_allocator_top import bfa_pkg::*; #(
   parameter int MAX_FRAMES    = 1024,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   bfa_req_if.sink    req_bus,
   bfa_rsp_if.source  rsp_bus,
   bfa_csr_if.sink    csr_bus
);

   cmd_type  dp_cmd;
   stat_type dp_stat;
   logic     req_fire;

   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // sequencer
   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // map, counters and search
   bfa_dpath #(
      .MAX_FRAMES    (MAX_FRAMES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_bus.op),
      .req_first  (req_bus.first_frame),
      .req_count  (req_bus.frame_count),
      .cfg_we     (csr_bus.valid),
      .cfg_data   (csr_bus.wdata),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .rsp_status (rsp_bus.status),
      .rsp_start  (rsp_bus.start_frame),
      .rsp_used   (rsp_bus.used_frames),
      .rsp_free   (rsp_bus.free_frames)
   );

   // at most one map access per cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.fill, dp_cmd.rd, dp_cmd.modify}))
      else $error("more than one map access in a cycle");

   // no request taken while the map sweep runs
   a_fill_blocks: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.fill |-> !req_bus.ready)
      else $error("request taken during map sweep");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("response overwritten before it was taken");

   // one request in work at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("second request taken while one is in work");

endmodule

// ===== tb/bitmap_frame_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top_test: self-checking bench for the frame allocator
// Drives init, alloc, release and mark requests through the request channel,
// predicts every response from a local copy of the frame map and used count,
// and checks each response field by field. Covers block_count extremes,
// exact fits, broken runs, saturation, unknown codes and a long response
// hold-off, then long random phases with random idling on both channels.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top_test import bfa_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAMES  = 1024;
   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int TAIL_CYCLES = 300;
   // codes above OP_MARK_UNUSED are undefined and must be ignored
   localparam logic [OP_W-1:0] OP_TOP_CODE = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  start_frame;
      logic [COUNT_W-1:0]  used_frames;
      logic [COUNT_W-1:0]  free_frames;
   } alloc_result_type;

   typedef struct {
      int first;
      int count;
   } frame_run_type;

   logic clock;
   logic reset;

   bfa_req_if req_bus ();
   bfa_rsp_if rsp_bus ();
   bfa_csr_if csr_bus ();

   bitmap_frame_allocator_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // local copy of the allocator state
   logic [MAX_FRAMES-1:0] frame_used    = '1;
   int                    used_count    = MAX_FRAMES;
   logic [COUNT_W-1:0]    block_count_q = BC_RESET;

   alloc_result_type pending_results[$];
   frame_run_type    live_runs[$];
   int               errors      = 0;
   int               cycles      = 0;
   int               rsp_hold    = 0;
   bit               steady_mode = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int eff_blocks();
      return (int'(block_count_q) > MAX_FRAMES) ? MAX_FRAMES : int'(block_count_q);
   endfunction

   function automatic void set_frames(input int first, input int n, input bit val);
      for (int i = 0; i < n; i++)
         frame_used[first + i] = val;
   endfunction

   function automatic void add_used(input int n, input int bc);
      used_count = (used_count + n > bc) ? bc : used_count + n;
   endfunction

   function automatic void sub_used(input int n);
      used_count = (n > used_count) ? 0 : used_count - n;
   endfunction

   // compute the response of one request and advance the local state
   function automatic alloc_result_type predict_request(input logic [OP_W-1:0] op,
                                                        input logic [FRAME_W-1:0] first,
                                                        input logic [COUNT_W-1:0] cnt);
      alloc_result_type r;
      int               bc;
      int               free_cnt;
      int               run_len;
      int               found;
      bit               hit;
      bit               range_bad;
      bc        = eff_blocks();
      r.status  = ST_OK;
      r.start_frame = first;
      range_bad = (cnt == 0) || (int'(first) + int'(cnt) > bc);
      case (op) inside
         OP_INIT: begin
            frame_used = '1;
            used_count = bc;
         end
         OP_ALLOC: begin
            if (cnt == 0 || int'(cnt) > bc) begin
               r.status = ST_BAD;
            end else begin
               free_cnt = (used_count >= bc) ? 0 : bc - used_count;
               run_len  = 0;
               found    = 0;
               hit      = 0;
               // first fit: restart the run at every used frame
               if (free_cnt >= int'(cnt)) begin
                  for (int i = 0; i < bc && !hit; i++) begin
                     if (frame_used[i]) begin
                        run_len = 0;
                     end else begin
                        run_len++;
                        if (run_len == int'(cnt)) begin
                           found = i + 1 - int'(cnt);
                           hit   = 1;
                        end
                     end
                  end
               end
               if (hit) begin
                  set_frames(found, int'(cnt), 1'b1);
                  add_used(int'(cnt), bc);
                  r.start_frame = FRAME_W'(found);
               end else begin
                  r.status = ST_NOSPACE;
               end
            end
         end
         OP_RELEASE, OP_MARK_USED, OP_MARK_UNUSED: begin
            if (range_bad) begin
               r.status = ST_BAD;
            end else if (op == OP_RELEASE) begin
               set_frames(int'(first), int'(cnt), 1'b0);
               sub_used(int'(cnt));
            end else if (op == OP_MARK_USED) begin
               set_frames(int'(first), int'(cnt), 1'b1);
               add_used(int'(cnt), bc);
            end else begin
               set_frames(int'(first), int'(cnt), 1'b0);
               sub_used(int'(cnt));
               frame_used[0] = 1'b1;
            end
         end
         default: ;
      endcase
      r.used_frames = COUNT_W'(used_count);
      r.free_frames = COUNT_W'((used_count >= bc) ? 0 : bc - used_count);
      return r;
   endfunction

   // response ready: a long hold-off while rsp_hold runs, else random idle bursts
   initial begin
      int idle_left;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (idle_left > 0) begin
            rsp_bus.ready <= 1'b0;
            idle_left--;
         end else if (!steady_mode && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            idle_left = $urandom_range(0, 8);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // check every accepted response against the oldest prediction
   initial begin
      alloc_result_type exp;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request pending");
               errors++;
            end else begin
               exp = pending_results.pop_front();
               if (rsp_bus.status !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.start_frame !== exp.start_frame) begin
                  $error("start_frame: expected %0d, got %0d", exp.start_frame,
                         rsp_bus.start_frame);
                  errors++;
               end
               if (rsp_bus.used_frames !== exp.used_frames) begin
                  $error("used_frames: expected %0d, got %0d", exp.used_frames,
                         rsp_bus.used_frames);
                  errors++;
               end
               if (rsp_bus.free_frames !== exp.free_frames) begin
                  $error("free_frames: expected %0d, got %0d", exp.free_frames,
                         rsp_bus.free_frames);
                  errors++;
               end
            end
         end
      end
   end

   // send one request, with an optional idle burst ahead of it
   task automatic send_request(input logic [OP_W-1:0] op, input int first, input int count);
      int               gap;
      alloc_result_type exp;
      gap = (!steady_mode && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.first_frame <= FRAME_W'(first);
      req_bus.frame_count <= COUNT_W'(count);
      do @(posedge clock); while (!req_bus.ready);
      exp = predict_request(op, FRAME_W'(first), COUNT_W'(count));
      pending_results.push_back(exp);
      if (op == OP_ALLOC && exp.status == ST_OK)
         live_runs.push_back('{int'(exp.start_frame), count});
   endtask

   // drop valid and hold until every predicted response has arrived
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
   endtask

   task automatic set_block_count(input logic [COUNT_W-1:0] value);
      wait_for_drain();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      block_count_q = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // everything is used after reset, so nothing can be allocated
   task automatic test_reset_state();
      send_request(OP_ALLOC, 0, 1);
   endtask

   task automatic test_full_range();
      send_request(OP_RELEASE, 0, MAX_FRAMES);
      send_request(OP_ALLOC, 1023, MAX_FRAMES);   // exact fit of the whole map
      send_request(OP_RELEASE, 1023, 1);
      send_request(OP_ALLOC, 0, 1);
      send_request(OP_ALLOC, 0, 0);               // zero count
      send_request(OP_ALLOC, 1023, 2047);         // count past block_count
      send_request(OP_RELEASE, 1023, 2);          // range past the end
      send_request(OP_RELEASE, 5, 0);
   endtask

   // a used frame inside a free stretch restarts the run
   task automatic test_run_restart();
      send_request(OP_RELEASE, 0, 2);
      send_request(OP_RELEASE, 3, 3);
      send_request(OP_ALLOC, 0, 3);
      send_request(OP_ALLOC, 0, 2);
   endtask

   task automatic test_marks_and_saturation();
      send_request(OP_MARK_UNUSED, 0, MAX_FRAMES); // frame 0 stays used
      send_request(OP_ALLOC, 0, MAX_FRAMES);
      send_request(OP_ALLOC, 0, MAX_FRAMES - 1);
      send_request(OP_MARK_USED, 1023, 1);
      send_request(OP_MARK_USED, 0, MAX_FRAMES);   // count saturates high
      send_request(OP_RELEASE, 0, MAX_FRAMES);
      send_request(OP_RELEASE, 0, 5);              // count saturates at zero
      send_request(OP_INIT, 0, 0);
   endtask

   task automatic test_unknown_ops();
      send_request(OP_W'(OP_MARK_UNUSED + 1), 1023, 2047);
      send_request(OP_W'(OP_TOP_CODE - 1), 512, 1024);
      send_request(OP_TOP_CODE, 0, 0);
   endtask

   task automatic test_block_count_extremes();
      set_block_count(COUNT_W'(1));
      send_request(OP_INIT, 0, 0);
      send_request(OP_RELEASE, 0, 1);
      send_request(OP_ALLOC, 0, 1);
      send_request(OP_ALLOC, 0, 2);
      send_request(OP_RELEASE, 1, 1);
      send_request(OP_MARK_UNUSED, 0, 1);
      set_block_count(COUNT_W'(0));
      send_request(OP_ALLOC, 0, 1);
      send_request(OP_MARK_USED, 0, 1);
      send_request(OP_INIT, 0, 0);
      set_block_count('1);
      send_request(OP_INIT, 0, 0);
      send_request(OP_RELEASE, 1000, 24);
      send_request(OP_ALLOC, 0, 24);
   endtask

   // hold responses off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      set_block_count(BC_RESET);
      send_request(OP_RELEASE, 0, MAX_FRAMES);
      wait_for_drain();
      rsp_hold = 400;
      repeat (12) send_request(OP_ALLOC, $urandom_range(0, 1023), 2);
      wait_for_drain();
   endtask

   task automatic run_random_phase(input logic [COUNT_W-1:0] bc_value, input int n_items);
      int            ebc;
      int            pick;
      int            first;
      int            count;
      int            hi;
      int            idx;
      frame_run_type run;
      set_block_count(bc_value);
      ebc = eff_blocks();
      live_runs.delete();
      send_request(OP_RELEASE, 0, ebc);
      for (int n = 0; n < n_items; n++) begin
         pick  = $urandom_range(0, 99);
         first = $urandom_range(0, ebc - 1);
         hi    = (ebc - first < 48) ? ebc - first : 48;
         count = $urandom_range(1, hi);
         if (pick < 40) begin
            // mostly small runs, now and then huge or malformed ones
            idx = $urandom_range(0, 19);
            if (idx < 14)
               count = $urandom_range(1, (ebc < 8) ? ebc : 8);
            else if (idx < 18)
               count = $urandom_range(1, (ebc < 64) ? ebc : 64);
            else if (idx == 18)
               count = $urandom_range(1, ebc);
            else
               count = $urandom_range(0, 2047);
            send_request(OP_ALLOC, $urandom_range(0, 1023), count);
         end else if (pick < 65) begin
            if (live_runs.size() > 0) begin
               idx = $urandom_range(0, live_runs.size() - 1);
               run = live_runs[idx];
               live_runs.delete(idx);
               send_request(OP_RELEASE, run.first, run.count);
            end else begin
               send_request(OP_RELEASE, first, count);
            end
         end else if (pick < 75) begin
            send_request(OP_MARK_USED, first, count);
         end else if (pick < 85) begin
            send_request(OP_MARK_UNUSED, first, count);
         end else if (pick < 90) begin
            send_request(OP_RELEASE, first, count);
         end else if (pick < 92) begin
            send_request(OP_INIT, first, count);
            live_runs.delete();
            send_request(OP_RELEASE, first, ebc - first);
         end else if (pick < 95) begin
            send_request(OP_W'($urandom_range(OP_MARK_UNUSED + 1, OP_TOP_CODE)),
                         $urandom_range(0, 1023), $urandom_range(0, 2047));
         end else begin
            send_request(OP_W'($urandom_range(OP_RELEASE, OP_MARK_UNUSED)),
                         $urandom_range(0, 1023), $urandom_range(0, 2047));
         end
      end
   endtask

   // main sequence
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_INIT;
      req_bus.first_frame  = '0;
      req_bus.frame_count  = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.wdata        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_full_range();
      test_run_restart();
      test_marks_and_saturation();
      test_unknown_ops();
      test_block_count_extremes();
      test_backpressure();

      run_random_phase(BC_RESET, 230);
      run_random_phase(COUNT_W'(37), 120);
      run_random_phase(COUNT_W'(1), 60);
      run_random_phase('1, 120);
      run_random_phase(COUNT_W'(200), 150);
      run_random_phase(COUNT_W'($urandom_range(2, 1023)), 150);
      steady_mode = 1;
      run_random_phase(BC_RESET, 150);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_req_if.sv
hw/rtl/bfa_rsp_if.sv
hw/rtl/bfa_csr_if.sv
hw/rtl/bfa_ram.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bfa_dpath.sv
hw/rtl/bitmap_frame_allocator_top.sv
tb/bitmap_frame_allocator_top_test.sv
